// File: rtl/core/rhpc_pkg.sv
// Shared constants and types for the RGB to HSL converter.
// No dependencies; used by every module in rtl/core.
package rhpc_pkg;

   localparam int CHANNEL_BITS_DEF = 8;
   localparam int Q_BITS           = 16;

   // Divider lanes carried side by side through the cell row
   localparam int NUM_LANES = 3;
   localparam int LANE_HUE  = 0;
   localparam int LANE_SAT  = 1;
   localparam int LANE_LIT  = 2;

   typedef struct packed {
      logic grey;      // max == min: hue and saturation are zero
      logic sat_one;   // saturation ratio is exactly 1.0
      logic lit_one;   // lightness ratio is exactly 1.0
   } rhpc_flags_type;

endpackage

// File: rtl/core/rhpc_prep.sv
// Front stage: max/min, sums and divider operands for the three lanes.
// Depends on rhpc_pkg.
module rhpc_prep
   import rhpc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int RW           = CHANNEL_BITS + 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                req_valid,
   input  logic [CHANNEL_BITS-1:0]             red,
   input  logic [CHANNEL_BITS-1:0]             green,
   input  logic [CHANNEL_BITS-1:0]             blue,
   output logic                                valid,
   output rhpc_flags_type                      flags,
   output logic [NUM_LANES-1:0][RW-1:0]        rem,
   output logic [NUM_LANES-1:0][RW-1:0]        den
);

   localparam int CB = CHANNEL_BITS;
   localparam int SW = RW + 1;
   localparam logic [CB:0] FS1 = {1'b0, {CB{1'b1}}};
   localparam logic [CB:0] FS2 = {{CB{1'b1}}, 1'b0};

   logic [CB-1:0] mx, mn, d;
   logic [CB:0]   sum, den_sat;
   logic [RW-1:0] d6;
   logic signed [SW-1:0] rs, gs, bs, d2s, d4s, d6s, hn;

   logic                         valid_ff, valid_in;
   rhpc_flags_type               flags_ff, flags_in;
   logic [NUM_LANES-1:0][RW-1:0] rem_ff, rem_in, den_ff, den_in;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      d   = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      den_sat = (sum < FS1) ? sum : (FS2 - sum);
      d6  = RW'({d, 2'b00}) + RW'({d, 1'b0});

      rs  = $signed(SW'(red));
      gs  = $signed(SW'(green));
      bs  = $signed(SW'(blue));
      d2s = $signed(SW'({d, 1'b0}));
      d4s = $signed(SW'({d, 2'b00}));
      d6s = $signed(SW'(d6));
      // blue wins ties over green, green over red
      if (blue == mx) begin
         hn = d4s + rs - gs;
      end else if (green == mx) begin
         hn = d2s + bs - rs;
      end else begin
         hn = gs - bs;
      end
      if (hn < 0) hn = hn + d6s;

      flags_in.grey    = (d == '0);
      flags_in.sat_one = ({1'b0, d} >= den_sat);
      flags_in.lit_one = (sum == FS2);

      rem_in[LANE_HUE] = hn[RW-1:0];
      den_in[LANE_HUE] = d6;
      rem_in[LANE_SAT] = RW'(d);
      den_in[LANE_SAT] = RW'(den_sat);
      rem_in[LANE_LIT] = RW'(sum);
      den_in[LANE_LIT] = RW'(FS2);

      valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff <= flags_in;
         rem_ff   <= rem_in;
         den_ff   <= den_in;
      end
   end

   assign valid = valid_ff;
   assign flags = flags_ff;
   assign rem   = rem_ff;
   assign den   = den_ff;

endmodule

// File: rtl/core/rhpc_div_cell.sv
// One restoring-division cell: develops one quotient bit per lane.
// Depends on rhpc_pkg; chained Q_BITS deep in the top level.
module rhpc_div_cell
   import rhpc_pkg::*;
#(
   parameter int RW = CHANNEL_BITS_DEF + 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rhpc_flags_type                in_flags,
   input  logic [NUM_LANES-1:0][RW-1:0]  in_rem,
   input  logic [NUM_LANES-1:0][RW-1:0]  in_den,
   input  logic [NUM_LANES-1:0][Q_BITS-1:0] in_q,
   output logic                          out_valid,
   output rhpc_flags_type                out_flags,
   output logic [NUM_LANES-1:0][RW-1:0]  out_rem,
   output logic [NUM_LANES-1:0][RW-1:0]  out_den,
   output logic [NUM_LANES-1:0][Q_BITS-1:0] out_q
);

   logic                             valid_ff;
   rhpc_flags_type                   flags_ff;
   logic [NUM_LANES-1:0][RW-1:0]     rem_ff, rem_in, den_ff;
   logic [NUM_LANES-1:0][Q_BITS-1:0] q_ff, q_in;
   logic [NUM_LANES-1:0][RW-1:0]     shifted;
   logic [NUM_LANES-1:0]             ge;

   // remainder stays below 2*den, so the shift never drops a set bit
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         shifted[i] = {in_rem[i][RW-2:0], 1'b0};
         ge[i]      = (shifted[i] >= in_den[i]);
         rem_in[i]  = ge[i] ? (shifted[i] - in_den[i]) : shifted[i];
         q_in[i]    = {in_q[i][Q_BITS-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff <= in_flags;
         rem_ff   <= rem_in;
         den_ff   <= in_den;
         q_ff     <= q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_q     = q_ff;

endmodule

// File: rtl/core/rgb_to_hsl_pixel_converter.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | req_red, req_green, req_blue
// rsp     | out       | rsp_valid/rsp_stall | rsp_hue, rsp_saturation, rsp_lightness
//
// One request per cycle sustained while req_stall is low; the path runs through the
// front stage, one division cell per quotient bit and the output register.
// The restoring-division cells form a pipelined row, all lanes in step.
// Synchronous active-high reset clears the valid bits only.
// A stalled result moves into a skid register; the cell row freezes and
// req_stall rises only while that skid register is occupied.
// Depends on rhpc_pkg, rhpc_prep and rhpc_div_cell.
module rgb_to_hsl_pixel_converter
   import rhpc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CHANNEL_BITS-1:0] req_red,
   input  logic [CHANNEL_BITS-1:0] req_green,
   input  logic [CHANNEL_BITS-1:0] req_blue,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [Q_BITS-1:0]       rsp_hue,
   output logic [Q_BITS-1:0]       rsp_saturation,
   output logic [Q_BITS-1:0]       rsp_lightness
);

   localparam int RW = CHANNEL_BITS + 4;
   localparam int PW = 3 * Q_BITS;
   localparam logic [Q_BITS-1:0] Q_MAX = {Q_BITS{1'b1}};

   logic en;

   logic                             st_valid [0:Q_BITS];
   rhpc_flags_type                   st_flags [0:Q_BITS];
   logic [NUM_LANES-1:0][RW-1:0]     st_rem   [0:Q_BITS];
   logic [NUM_LANES-1:0][RW-1:0]     st_den   [0:Q_BITS];
   logic [NUM_LANES-1:0][Q_BITS-1:0] st_q     [0:Q_BITS];

   logic [PW-1:0] res;
   logic [Q_BITS-1:0] hue_v, sat_v, lit_v;
   logic          p_fire;

   logic          out_valid_ff, out_valid_in;
   logic [PW-1:0] out_data_ff, out_data_in;
   logic          skid_valid_ff, skid_valid_in;
   logic [PW-1:0] skid_data_ff, skid_data_in;
   logic          out_load, skid_load;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   rhpc_prep #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .RW           (RW)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .valid     (st_valid[0]),
      .flags     (st_flags[0]),
      .rem       (st_rem[0]),
      .den       (st_den[0])
   );

   assign st_q[0] = '0;

   for (genvar k = 0; k < Q_BITS; k++) begin : g_cell
      rhpc_div_cell #(
         .RW (RW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (st_valid[k]),
         .in_flags  (st_flags[k]),
         .in_rem    (st_rem[k]),
         .in_den    (st_den[k]),
         .in_q      (st_q[k]),
         .out_valid (st_valid[k+1]),
         .out_flags (st_flags[k+1]),
         .out_rem   (st_rem[k+1]),
         .out_den   (st_den[k+1]),
         .out_q     (st_q[k+1])
      );
   end

   // final remainders are unused; the flags override degenerate lanes
   always_comb begin
      hue_v = st_flags[Q_BITS].grey ? '0 : st_q[Q_BITS][LANE_HUE];
      if (st_flags[Q_BITS].grey) begin
         sat_v = '0;
      end else if (st_flags[Q_BITS].sat_one) begin
         sat_v = Q_MAX;
      end else begin
         sat_v = st_q[Q_BITS][LANE_SAT];
      end
      lit_v = st_flags[Q_BITS].lit_one ? Q_MAX : st_q[Q_BITS][LANE_LIT];
      res   = {hue_v, sat_v, lit_v};
   end

   assign p_fire = st_valid[Q_BITS] && en;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      out_load      = 1'b0;
      skid_load     = 1'b0;
      if (!out_valid_ff || !rsp_stall) begin
         out_load = 1'b1;
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = p_fire;
            out_data_in  = res;
         end
      end else if (p_fire) begin
         skid_load     = 1'b1;
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
      if (skid_load) begin
         skid_data_ff <= skid_data_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hue        = out_data_ff[3*Q_BITS-1:2*Q_BITS];
   assign rsp_saturation = out_data_ff[2*Q_BITS-1:Q_BITS];
   assign rsp_lightness  = out_data_ff[Q_BITS-1:0];

endmodule
